// ===== design/kmwf_pkg.sv =====
// ----------------------------------------------------------------------------
// kmwf_pkg
// Shared widths, register defaults, register indexes and the link types
// between the keypad message waveform framer's sequencer and packer.
// ----------------------------------------------------------------------------
package kmwf_pkg;

    localparam int unsigned MSG_BYTES   = 4;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned MSG_W       = MSG_BYTES * BYTE_W;
    localparam int unsigned VBITS_W     = 4;
    localparam int unsigned PRE_W       = 6;
    localparam int unsigned MARK_W      = 5;
    localparam int unsigned SPB_W       = 3;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 6;
    localparam int unsigned SEG_W       = 6;   // widest segment length

    localparam logic [PRE_W-1:0]  PRE_ON_RST  = PRE_W'(29);
    localparam logic [PRE_W-1:0]  PRE_OFF_RST = PRE_W'(29);
    localparam logic [MARK_W-1:0] MARK_RST    = MARK_W'(5);
    localparam logic [SPB_W-1:0]  SPB_RST     = SPB_W'(2);

    localparam logic [SPB_W-1:0]  SPB_MIN     = SPB_W'(1);
    localparam logic [SPB_W-1:0]  SPB_MAX     = SPB_W'(4);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_ON  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_OFF = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MARK    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPB     = CFG_IDX_W'(3);

    typedef struct packed {
        logic [PRE_W-1:0]  pre_on;
        logic [PRE_W-1:0]  pre_off;
        logic [MARK_W-1:0] marker;
        logic [SPB_W-1:0]  spb;
    } t_cfg;

    // sequencer -> packer
    typedef struct packed {
        logic bit_valid;
        logic bit_val;
        logic flush;
    } t_bit_xfer;

    function automatic logic [SPB_W-1:0] clamp_spb(input logic [SPB_W-1:0] spb);
        logic [SPB_W-1:0] r;
        r = spb;
        if (spb < SPB_MIN) begin
            r = SPB_MIN;
        end else if (spb > SPB_MAX) begin
            r = SPB_MAX;
        end
        return r;
    endfunction

endpackage

// ===== design/kmwf_in_if.sv =====
// ----------------------------------------------------------------------------
// kmwf_in_if
// Message channel: four message bytes, byte_0 sent first on the line.
// ----------------------------------------------------------------------------
interface kmwf_in_if
    import kmwf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_0;
    logic [BYTE_W-1:0] byte_1;
    logic [BYTE_W-1:0] byte_2;
    logic [BYTE_W-1:0] byte_3;

    modport source (output valid, output byte_0, output byte_1, output byte_2,
                    output byte_3, input ready);
    modport sink   (input valid, input byte_0, input byte_1, input byte_2,
                    input byte_3, output ready);
endinterface

// ===== design/kmwf_out_if.sv =====
// ----------------------------------------------------------------------------
// kmwf_out_if
// Waveform channel: one packed waveform byte per transfer.
// ----------------------------------------------------------------------------
interface kmwf_out_if
    import kmwf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  wave_byte;
    logic [VBITS_W-1:0] valid_bits;
    logic               last_byte;

    modport source (output valid, output wave_byte, output valid_bits,
                    output last_byte, input ready);
    modport sink   (input valid, input wave_byte, input valid_bits,
                    input last_byte, output ready);
endinterface

// ===== design/kmwf_seq.sv =====
// ----------------------------------------------------------------------------
// kmwf_seq
// Segment sequencer: walks preamble, markers and UART bits with one shared
// segment counter and hands out one line bit per cycle while the packer is ready.
// ----------------------------------------------------------------------------
module kmwf_seq
    import kmwf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MSG_W-1:0] i_msg,
    input  t_cfg             i_cfg,
    input  logic             i_bit_ready,
    output logic             o_idle,
    output t_bit_xfer        o_xfer
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_PRE_ON  = 4'd1;
    localparam logic [3:0] PH_PRE_OFF = 4'd2;
    localparam logic [3:0] PH_MARK    = 4'd3;
    localparam logic [3:0] PH_START   = 4'd4;
    localparam logic [3:0] PH_DATA    = 4'd5;
    localparam logic [3:0] PH_PARITY  = 4'd6;
    localparam logic [3:0] PH_END     = 4'd7;
    localparam logic [3:0] PH_FLUSH   = 4'd8;

    logic [3:0]       r_phase, n_phase;
    logic [SEG_W-1:0] r_cnt,   n_cnt;
    logic [MSG_W-1:0] r_msg,   n_msg;
    logic [1:0]       r_k,     n_k;
    logic [2:0]       r_b,     n_b;

    logic [SEG_W-1:0]  seg_len;
    logic              seg_active;
    logic              line_bit;
    logic [BYTE_W-1:0] cur_byte;
    logic [SPB_W-1:0]  spb;

    assign spb      = clamp_spb(i_cfg.spb);
    assign cur_byte = r_msg[BYTE_W-1:0];

    always_comb begin
        seg_len    = '0;
        line_bit   = 1'b0;
        seg_active = 1'b1;
        unique case (r_phase)
            PH_PRE_ON:  begin seg_len = i_cfg.pre_on;  line_bit = 1'b1; end
            PH_PRE_OFF: begin seg_len = i_cfg.pre_off; line_bit = 1'b0; end
            PH_MARK:    begin seg_len = SEG_W'(i_cfg.marker); line_bit = 1'b1; end
            PH_START:   begin seg_len = SEG_W'(spb); line_bit = 1'b0; end
            PH_DATA:    begin seg_len = SEG_W'(spb); line_bit = cur_byte[r_b]; end
            PH_PARITY:  begin seg_len = SEG_W'(spb); line_bit = ^cur_byte; end
            PH_END:     begin seg_len = SEG_W'(i_cfg.marker); line_bit = 1'b1; end
            default:    begin seg_active = 1'b0; end
        endcase
    end

    assign o_idle           = (r_phase == PH_IDLE);
    assign o_xfer.bit_valid = seg_active && (r_cnt != seg_len);
    assign o_xfer.bit_val   = line_bit;
    assign o_xfer.flush     = (r_phase == PH_FLUSH);

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_msg   = r_msg;
        n_k     = r_k;
        n_b     = r_b;
        if (o_idle) begin
            if (i_start) begin
                n_phase = PH_PRE_ON;
                n_cnt   = '0;
                n_msg   = i_msg;
                n_k     = '0;
                n_b     = '0;
            end
        end else if (o_xfer.flush) begin
            if (i_bit_ready) begin
                n_phase = PH_IDLE;
            end
        end else if (o_xfer.bit_valid) begin
            if (i_bit_ready) begin
                n_cnt = r_cnt + SEG_W'(1);
            end
        end else begin
            // segment finished: step to the next one
            n_cnt = '0;
            unique case (r_phase)
                PH_PRE_ON:  n_phase = PH_PRE_OFF;
                PH_PRE_OFF: n_phase = PH_MARK;
                PH_MARK:    n_phase = PH_START;
                PH_START: begin
                    n_phase = PH_DATA;
                    n_b     = '0;
                end
                PH_DATA: begin
                    if (r_b == 3'd7) begin
                        n_phase = PH_PARITY;
                    end else begin
                        n_b = r_b + 3'd1;
                    end
                end
                PH_PARITY: begin
                    n_msg = r_msg >> BYTE_W;
                    if (r_k == 2'(MSG_BYTES - 1)) begin
                        n_phase = PH_END;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_phase = PH_MARK;
                    end
                end
                PH_END:  n_phase = PH_FLUSH;
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_k     <= '0;
            r_b     <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_b     <= n_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_msg <= n_msg;
    end

endmodule

// ===== design/kmwf_pack.sv =====
// ----------------------------------------------------------------------------
// kmwf_pack
// Bit packer: gathers line bits MSB first and holds a full byte until it is
// known whether more bits follow, then loads the output register.
// ----------------------------------------------------------------------------
module kmwf_pack
    import kmwf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_bit_xfer  i_xfer,
    output logic       o_bit_ready,
    kmwf_out_if.source o_wave
);

    logic [BYTE_W-1:0]  r_acc,   n_acc;
    logic [VBITS_W-1:0] r_fill,  n_fill;
    logic               r_valid, n_valid;
    logic [BYTE_W-1:0]  r_byte,  n_byte;
    logic [VBITS_W-1:0] r_vbits, n_vbits;
    logic               r_last,  n_last;

    logic sink_ok;
    logic acc_full;

    assign sink_ok     = !r_valid || o_wave.ready;
    assign acc_full    = (r_fill == VBITS_W'(BYTE_W));
    assign o_bit_ready = i_xfer.flush ? sink_ok : (!acc_full || sink_ok);

    always_comb begin
        n_acc   = r_acc;
        n_fill  = r_fill;
        n_byte  = r_byte;
        n_vbits = r_vbits;
        n_last  = r_last;
        n_valid = r_valid && !o_wave.ready;
        if (i_xfer.flush && sink_ok) begin
            // left-align the partial byte, zero padding below
            n_byte  = r_acc << (VBITS_W'(BYTE_W) - r_fill);
            n_vbits = r_fill;
            n_last  = 1'b1;
            n_valid = 1'b1;
            n_fill  = '0;
        end else if (i_xfer.bit_valid && o_bit_ready) begin
            if (acc_full) begin
                n_byte  = r_acc;
                n_vbits = VBITS_W'(BYTE_W);
                n_last  = 1'b0;
                n_valid = 1'b1;
                n_acc   = {{(BYTE_W-1){1'b0}}, i_xfer.bit_val};
                n_fill  = VBITS_W'(1);
            end else begin
                n_acc  = {r_acc[BYTE_W-2:0], i_xfer.bit_val};
                n_fill = r_fill + VBITS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_byte  <= n_byte;
        r_vbits <= n_vbits;
        r_last  <= n_last;
    end

    assign o_wave.valid      = r_valid;
    assign o_wave.wave_byte  = r_byte;
    assign o_wave.valid_bits = r_vbits;
    assign o_wave.last_byte  = r_last;

endmodule

// ===== design/keypad_message_waveform_framer_top.sv =====
// ----------------------------------------------------------------------------
// keypad_message_waveform_framer_top
// Frames a four-byte keypad message as a packed line waveform.
//
//   channel   dir  contents                                  transfer
//   i_msg     in   byte_0..byte_3                            valid & ready
//   o_wave    out  wave_byte, valid_bits, last_byte          valid & ready
//   i_cfg_*   in   register index, data                      i_cfg_we high
//
// One line bit per cycle from the segment sequencer while the output does not
// stall, plus a boundary step at each of the 47 segment boundaries per message,
// then a flush step and an idle step before the next transfer.
// i_msg.ready is high only while the sequencer is idle.
// A stalled output holds the sequencer once the next byte is complete.
// Reset is synchronous and restores the register defaults.
// ----------------------------------------------------------------------------
module keypad_message_waveform_framer_top
    import kmwf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    kmwf_in_if.sink               i_msg,
    kmwf_out_if.source            o_wave,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg, n_cfg;
    t_bit_xfer xfer;
    logic      bit_ready;
    logic      seq_idle;
    logic      start;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PRE_ON:  n_cfg.pre_on  = i_cfg_data[PRE_W-1:0];
                CFG_PRE_OFF: n_cfg.pre_off = i_cfg_data[PRE_W-1:0];
                CFG_MARK:    n_cfg.marker  = i_cfg_data[MARK_W-1:0];
                CFG_SPB:     n_cfg.spb     = i_cfg_data[SPB_W-1:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pre_on  <= PRE_ON_RST;
            r_cfg.pre_off <= PRE_OFF_RST;
            r_cfg.marker  <= MARK_RST;
            r_cfg.spb     <= SPB_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign i_msg.ready = seq_idle;
    assign start       = i_msg.valid && seq_idle;

    kmwf_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_msg       ({i_msg.byte_3, i_msg.byte_2, i_msg.byte_1, i_msg.byte_0}),
        .i_cfg       (r_cfg),
        .i_bit_ready (bit_ready),
        .o_idle      (seq_idle),
        .o_xfer      (xfer)
    );

    kmwf_pack u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_xfer      (xfer),
        .o_bit_ready (bit_ready),
        .o_wave      (o_wave)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> !i_msg.ready)
        else $error("message accepted while framing previous one");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_idle |-> (!xfer.bit_valid && !xfer.flush))
        else $error("sequencer emits while idle");

    a_full_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wave.valid && !o_wave.last_byte) |-> (o_wave.valid_bits == VBITS_W'(BYTE_W)))
        else $error("non-final byte not full");

    a_last_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wave.valid && o_wave.last_byte) |->
        (o_wave.valid_bits != '0 && o_wave.valid_bits <= VBITS_W'(BYTE_W)))
        else $error("final byte bit count out of range");
`endif

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the keypad message waveform framer. Messages are sent over
// the message channel at random intervals. The expected waveform bytes are
// built bit by bit from the current register values, and each waveform
// transfer is checked against them in order. Directed messages cover the
// register extremes and the clamping cases. Random register settings and
// random message bytes follow. The output side stalls on a pattern of its
// own.
// ----------------------------------------------------------------------------
module tb_top;
    import kmwf_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0]  wave_byte;
        logic [VBITS_W-1:0] valid_bits;
        logic               last_byte;
    } t_wave_beat;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    kmwf_in_if  msg_if();
    kmwf_out_if wave_if();

    keypad_message_waveform_framer_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_msg      (msg_if),
        .o_wave     (wave_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // register shadow
    logic [PRE_W-1:0]  pre_on_len;
    logic [PRE_W-1:0]  pre_off_len;
    logic [MARK_W-1:0] marker_len;
    logic [SPB_W-1:0]  spb_setting;

    t_wave_beat        expected_wave[$];
    logic [BYTE_W-1:0] pack_byte;
    int                pack_fill;

    int errors = 0;
    int msg_count;
    int beat_count = 0;
    int cfg_count;
    int burst_left;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // waveform predictor
    // ------------------------------------------------------------------
    function automatic void push_line_bits(input logic value, input int count);
        for (int i = 0; i < count; i++) begin
            pack_byte[3'(BYTE_W-1-pack_fill)] = value;
            pack_fill++;
            if (pack_fill == BYTE_W) begin
                expected_wave.push_back('{pack_byte, VBITS_W'(8), 1'b0});
                pack_byte = '0;
                pack_fill = 0;
            end
        end
    endfunction

    function automatic void frame_message(input logic [BYTE_W-1:0] b0,
                                          input logic [BYTE_W-1:0] b1,
                                          input logic [BYTE_W-1:0] b2,
                                          input logic [BYTE_W-1:0] b3);
        logic [BYTE_W-1:0] msg [MSG_BYTES];
        int                reps;
        logic              parity;
        msg[0] = b0;
        msg[1] = b1;
        msg[2] = b2;
        msg[3] = b3;
        reps = (spb_setting == 0) ? 1 : (spb_setting > 4) ? 4 : int'(spb_setting);
        pack_byte = '0;
        pack_fill = 0;
        push_line_bits(1'b1, int'(pre_on_len));
        push_line_bits(1'b0, int'(pre_off_len));
        for (int k = 0; k < MSG_BYTES; k++) begin
            parity = ^msg[k];
            push_line_bits(1'b1, int'(marker_len));
            push_line_bits(1'b0, reps);
            for (int b = 0; b < BYTE_W; b++) begin
                push_line_bits(msg[k][b], reps);
            end
            push_line_bits(parity, reps);
        end
        push_line_bits(1'b1, int'(marker_len));
        // partial tail byte is zero padded; a full one just gets the last flag
        if (pack_fill > 0) begin
            expected_wave.push_back('{pack_byte, VBITS_W'(pack_fill), 1'b1});
        end else begin
            expected_wave[expected_wave.size()-1].last_byte = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_wave_beat want;
        if (i_rst_n && wave_if.valid && wave_if.ready) begin
            beat_count++;
            if (expected_wave.size() == 0) begin
                errors++;
                $display("%0t: unexpected waveform transfer: wave_byte=%02h valid_bits=%0d last=%0b",
                         $time, wave_if.wave_byte, wave_if.valid_bits, wave_if.last_byte);
            end else begin
                want = expected_wave.pop_front();
                if (wave_if.wave_byte !== want.wave_byte) begin
                    errors++;
                    $display("%0t: wave_byte mismatch: expected %02h, actual %02h",
                             $time, want.wave_byte, wave_if.wave_byte);
                end
                if (wave_if.valid_bits !== want.valid_bits) begin
                    errors++;
                    $display("%0t: valid_bits mismatch: expected %0d, actual %0d",
                             $time, want.valid_bits, wave_if.valid_bits);
                end
                if (wave_if.last_byte !== want.last_byte) begin
                    errors++;
                    $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                             $time, want.last_byte, wave_if.last_byte);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output stall pattern: runs of always-ready, light and heavy stalls
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int stall_run = 0;

    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_run  = $urandom_range(20, 200);
        end
        stall_run--;
        case (stall_mode)
            0:       wave_if.ready <= 1'b1;
            1:       wave_if.ready <= ($urandom_range(0, 3) != 0);
            default: wave_if.ready <= 1'($urandom_range(0, 1));
        endcase
    end

    // ------------------------------------------------------------------
    // stimulus helpers (called at a falling edge, return at one)
    // ------------------------------------------------------------------
    task automatic set_config(input logic [CFG_DATA_W-1:0] on_val,
                              input logic [CFG_DATA_W-1:0] off_val,
                              input logic [CFG_DATA_W-1:0] mark_val,
                              input logic [CFG_DATA_W-1:0] spb_val);
        logic [CFG_DATA_W-1:0] vals [4];
        logic [CFG_IDX_W-1:0]  idxs [4];
        vals = '{on_val, off_val, mark_val, spb_val};
        idxs = '{CFG_PRE_ON, CFG_PRE_OFF, CFG_MARK, CFG_SPB};
        for (int r = 0; r < 4; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[r];
            i_cfg_data <= vals[r];
            @(negedge i_clk);
            case (idxs[r])
                CFG_PRE_ON:  pre_on_len  = vals[r][PRE_W-1:0];
                CFG_PRE_OFF: pre_off_len = vals[r][PRE_W-1:0];
                CFG_MARK:    marker_len  = vals[r][MARK_W-1:0];
                CFG_SPB:     spb_setting = vals[r][SPB_W-1:0];
                default:     ;
            endcase
            cfg_count++;
        end
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_msg(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
                            input logic [BYTE_W-1:0] b2, input logic [BYTE_W-1:0] b3);
        int gap;
        msg_if.byte_0 <= b0;
        msg_if.byte_1 <= b1;
        msg_if.byte_2 <= b2;
        msg_if.byte_3 <= b3;
        if (!msg_if.valid) msg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!msg_if.ready);
        frame_message(b0, b1, b2, b3);
        msg_count++;
        @(negedge i_clk);
        // valid stays up within a burst; the next call follows in this step
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            msg_if.valid <= 1'b0;
            burst_left = $urandom_range(0, 4);
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_random_msg();
        send_msg(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                 BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        if (msg_if.valid) msg_if.valid <= 1'b0;
        while (expected_wave.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_preamble();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            default: return CFG_DATA_W'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_marker();
        // top bit lies beyond the register and must be dropped
        case ($urandom_range(0, 5))
            0:       return {$urandom_range(0, 1) == 1, 5'd0};
            1:       return 6'd1;
            2:       return 6'd31;
            default: return CFG_DATA_W'($urandom_range(0, 63));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_msg(8'h00, 8'h00, 8'h00, 8'h00);
        send_msg(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_msg(8'h01, 8'h80, 8'h55, 8'hAA);
        send_random_msg();
        wait_drained();
    endtask

    task automatic test_register_extremes();
        // no preamble, no markers, zero samples per bit runs as one
        set_config(6'd0, 6'd0, 6'd0, 6'd0);
        send_msg(8'hFF, 8'h00, 8'h7F, 8'hFE);
        send_msg(8'h00, 8'hFF, 8'h80, 8'h01);
        wait_drained();
        // longest waveform, samples per bit clamped to four
        set_config(6'd63, 6'd63, 6'd31, 6'd7);
        send_msg(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_msg(8'h00, 8'h00, 8'h00, 8'h00);
        wait_drained();
        set_config(6'd63, 6'd0, 6'd31, 6'd5);
        send_msg(8'hA5, 8'h5A, 8'hC3, 8'h3C);
        wait_drained();
        set_config(6'd0, 6'd63, 6'd1, 6'd6);
        send_msg(8'h12, 8'h34, 8'h56, 8'h78);
        wait_drained();
        // waveform ends exactly on a byte boundary
        set_config(6'd3, 6'd0, 6'd1, 6'd1);
        send_msg(8'hF0, 8'h0F, 8'h33, 8'hCC);
        wait_drained();
        // upper data bits beyond the register width
        set_config(6'd10, 6'd20, 6'h25, 6'h3C);
        send_random_msg();
        send_random_msg();
        wait_drained();
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 12; p++) begin
            set_config(pick_preamble(), pick_preamble(), pick_marker(),
                       CFG_DATA_W'($urandom_range(0, 63)));
            for (int n = 0; n < 37; n++) begin
                send_random_msg();
            end
            wait_drained();
        end
    endtask

    initial begin
        msg_count   = 0;
        cfg_count   = 0;
        burst_left  = 0;
        pre_on_len  = PRE_ON_RST;
        pre_off_len = PRE_OFF_RST;
        marker_len  = MARK_RST;
        spb_setting = SPB_RST;
        pack_byte   = '0;
        pack_fill   = 0;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        msg_if.valid   = 1'b0;
        msg_if.byte_0  = '0;
        msg_if.byte_1  = '0;
        msg_if.byte_2  = '0;
        msg_if.byte_3  = '0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        test_reset_defaults();
        test_register_extremes();
        test_random_traffic();

        $display("Sent %0d messages under %0d register writes, checked %0d waveform bytes",
                 msg_count, cfg_count, beat_count);
        $display("Settings spanned empty and full preambles, zero to 31 marker bits "
                 , "and every samples-per-bit code");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("Timeout: %0d waveform bytes still expected", expected_wave.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
